// ===== rtl/core/euclidean_rhythm_generator_top_macros.svh =====
// Assertion macros for the rhythm generator checker.
`ifndef EUCLIDEAN_RHYTHM_GENERATOR_TOP_MACROS_SVH
`define EUCLIDEAN_RHYTHM_GENERATOR_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ERG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ERG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/erg_pkg.sv =====
// Package with types, constants and step functions of the rhythm generator.
package erg_pkg;

   // Width of the pattern word and of the step counts.
   localparam int PAT_W = 64;
   localparam int CNT_W = 7;
   localparam int SUM_W = CNT_W + 1;

   // Kind of result that an item produces.
   typedef enum logic [1:0] {
      KIND_GROUP,
      KIND_ZERO,
      KIND_ONES
   } kind_type;

   // One pipeline stage: front and remainder groups and their counts.
   typedef struct packed {
      logic             valid;
      kind_type         kind;
      logic [PAT_W-1:0] fa;
      logic [PAT_W-1:0] fb;
      logic [CNT_W-1:0] la;
      logic [CNT_W-1:0] lb;
      logic [CNT_W-1:0] na;
      logic [CNT_W-1:0] nb;
      logic [CNT_W-1:0] steps;
   } grp_type;

   // Mask with the lowest n bits set.
   function automatic logic [PAT_W-1:0] low_mask(input logic [SUM_W-1:0] n);
      logic [PAT_W-1:0] res;
      if (n >= SUM_W'(PAT_W)) begin
         res = '1;
      end else begin
         res = ~({PAT_W{1'b1}} << n);
      end
      return res;
   endfunction

   // Left shift that yields zero once the shift reaches the word width.
   function automatic logic [PAT_W-1:0] shl_safe(input logic [PAT_W-1:0] v,
                                                 input logic [SUM_W-1:0] n);
      logic [PAT_W-1:0] res;
      if (n >= SUM_W'(PAT_W)) begin
         res = '0;
      end else begin
         res = v << n;
      end
      return res;
   endfunction

   // One grouping round: pair front groups with remainder groups.
   function automatic grp_type grp_iter(input grp_type g);
      grp_type          r;
      logic [CNT_W-1:0] m;
      logic [SUM_W-1:0] lsum;
      r = g;
      if (g.valid && (g.kind == KIND_GROUP) && (g.nb > CNT_W'(1))) begin
         m    = (g.na < g.nb) ? g.na : g.nb;
         lsum = SUM_W'(g.la) + SUM_W'(g.lb);
         if (g.na > g.nb) begin
            r.fb = g.fa;
            r.lb = g.la;
            r.nb = g.na - m;
         end else begin
            r.nb = g.nb - m;
         end
         r.fa = (g.fa | shl_safe(g.fb, SUM_W'(g.la))) & low_mask(lsum);
         r.la = lsum[CNT_W-1:0];
         r.na = m;
      end
      return r;
   endfunction

   // One doubling round: the front group word holds twice as many copies.
   function automatic grp_type grp_dbl(input grp_type g);
      grp_type          r;
      logic [SUM_W-1:0] dlen;
      r    = g;
      dlen = SUM_W'(g.la) << 1;
      if (g.la < CNT_W'(PAT_W)) begin
         r.fa = g.fa | shl_safe(g.fa, SUM_W'(g.la));
         r.la = (dlen > SUM_W'(PAT_W)) ? CNT_W'(PAT_W) : dlen[CNT_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/euclidean_rhythm_generator_top.sv =====
// Euclidean rhythm generator: Bjorklund grouping in a deep pipeline.
//
// A transaction of hits and steps yields one pattern word with the clamped
// length; zero steps yield nothing. The block takes one transaction per cycle
// while the pipeline is not stalled. Each result passes through a register
// chain: one entry register, one stage per grouping round (at most
// MAX_STEPS - 1 rounds), the clog2(MAX_STEPS) stages that replicate the front
// group and one output register. A stall on the result side holds the whole
// pipeline and is passed back on req_stall.
module euclidean_rhythm_generator_top #(
   parameter int MAX_STEPS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [erg_pkg::CNT_W-1:0] req_hits,
   input  logic [erg_pkg::CNT_W-1:0] req_steps,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [erg_pkg::PAT_W-1:0] rsp_pattern,
   output logic [erg_pkg::CNT_W-1:0] rsp_length
);
   import erg_pkg::*;

   localparam int ITERS  = MAX_STEPS - 1;
   localparam int DBLS   = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int STAGES = ITERS + DBLS + 1;

   grp_type          pipe_ff [STAGES];
   grp_type          pipe_in [STAGES];
   grp_type          entry_grp;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [PAT_W-1:0] rsp_pattern_ff;
   logic [PAT_W-1:0] rsp_pattern_in;
   logic [CNT_W-1:0] rsp_length_ff;
   logic [CNT_W-1:0] rsp_length_in;
   logic             advance;
   logic [CNT_W-1:0] steps_clamp;
   logic [CNT_W-1:0] front_len;
   grp_type          last;

   // The pipeline moves whenever the output register is free or taken.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Entry stage: clamp steps and sort out the trivial patterns.
   always_comb begin
      steps_clamp = (req_steps > CNT_W'(MAX_STEPS)) ? CNT_W'(MAX_STEPS) : req_steps;
      entry_grp.valid = req_valid && (req_steps != '0);
      entry_grp.steps = steps_clamp;
      entry_grp.fa    = PAT_W'(1);
      entry_grp.fb    = '0;
      entry_grp.la    = CNT_W'(1);
      entry_grp.lb    = CNT_W'(1);
      entry_grp.na    = req_hits;
      entry_grp.nb    = steps_clamp - req_hits;
      priority if (req_hits == '0) begin
         entry_grp.kind = KIND_ZERO;
      end else if (req_hits >= steps_clamp) begin
         entry_grp.kind = KIND_ONES;
      end else begin
         entry_grp.kind = KIND_GROUP;
      end
   end

   // Grouping rounds, then doubling rounds that replicate the front group.
   always_comb begin
      pipe_in[0] = entry_grp;
      for (int k = 0; k < STAGES - 1; k++) begin
         if (k < ITERS) begin
            pipe_in[k+1] = grp_iter(pipe_ff[k]);
         end else begin
            pipe_in[k+1] = grp_dbl(pipe_ff[k]);
         end
      end
   end

   // Output stage: front copies, then the single remainder group if any.
   always_comb begin
      last          = pipe_ff[STAGES-1];
      front_len     = (last.nb == CNT_W'(1)) ? (last.steps - last.lb) : last.steps;
      rsp_valid_in  = last.valid;
      rsp_length_in = last.steps;
      unique case (last.kind)
         KIND_ZERO:  rsp_pattern_in = '0;
         KIND_ONES:  rsp_pattern_in = low_mask(SUM_W'(last.steps));
         KIND_GROUP: rsp_pattern_in =
            ((last.fa & low_mask(SUM_W'(front_len)))
             | ((last.nb == CNT_W'(1)) ? shl_safe(last.fb, SUM_W'(front_len)) : '0))
            & low_mask(SUM_W'(last.steps));
         default:    rsp_pattern_in = '0;
      endcase
   end

   // Pipeline and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) begin
            pipe_ff[k].valid <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         for (int k = 0; k < STAGES; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
         rsp_valid_ff   <= rsp_valid_in;
         rsp_pattern_ff <= rsp_pattern_in;
         rsp_length_ff  <= rsp_length_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pattern = rsp_pattern_ff;
   assign rsp_length  = rsp_length_ff;

endmodule

// ===== rtl/core/erg_checker.sv =====
// Port checker for the rhythm generator and its bind to the top level.
`include "euclidean_rhythm_generator_top_macros.svh"

module erg_checker #(
   parameter int MAX_STEPS = 64
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [erg_pkg::PAT_W-1:0] rsp_pattern,
   input logic [erg_pkg::CNT_W-1:0] rsp_length
);
   import erg_pkg::*;

   // A stalled result stays put.
   `ERG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_pattern) && $stable(rsp_length), "stalled result changed")

   // The length is always within the clamped range.
   `ERG_ASSERT_SAME(a_len_range, clock, reset, rsp_valid,
      (rsp_length != '0) && (rsp_length <= CNT_W'(MAX_STEPS)), "result length out of range")

   // No onset lies beyond the pattern length.
   `ERG_ASSERT_SAME(a_pat_clean, clock, reset, rsp_valid,
      (rsp_pattern >> rsp_length) == '0, "pattern bits beyond length")

   // The input is held back exactly when a result waits on a stall.
   `ERG_ASSERT_SAME(a_back_press, clock, reset, 1'b1,
      req_stall == (rsp_valid && rsp_stall), "input stall does not follow output stall")

endmodule

bind euclidean_rhythm_generator_top erg_checker #(.MAX_STEPS(MAX_STEPS)) u_erg_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_pattern (rsp_pattern),
   .rsp_length  (rsp_length)
);
